// File: rtl/type_length_message_deframer_assert.svh
// Assertion macros used by the deframer top level.
`ifndef TYPE_LENGTH_MESSAGE_DEFRAMER_ASSERT_SVH
`define TYPE_LENGTH_MESSAGE_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLMD_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("deframer assertion failed");

// next-cycle implication
`define TLMD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("deframer assertion failed");

`else

`define TLMD_ASSERT_NOW(label, clk, rst, a, b)
`define TLMD_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// File: rtl/tlmd_pkg.sv
// Types, constants and codes of the type-length message deframer.
package tlmd_pkg;

  localparam int TYPE_ENTRIES = 4;
  localparam int LIMIT_WIDTH  = 24;
  localparam int REG_COUNT    = 4;
  localparam int HEADER_BYTES = 5;
  localparam int LOOKUP_N     = (TYPE_ENTRIES < REG_COUNT) ? TYPE_ENTRIES : REG_COUNT;
  localparam int REG_IDX_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 58;
  localparam int LEN_W        = 32;

  typedef struct packed {
    logic        valid;
    logic        no_limit;
    logic [23:0] max_len;
    logic [23:0] min_len;
    logic [7:0]  type_id;
  } type_entry_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNKNOWN_TYPE = 3'd1,
    ERR_TOO_SHORT    = 3'd2,
    ERR_TOO_LONG     = 3'd3,
    ERR_ZERO_LEN     = 3'd4
  } err_code_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic halted;
    logic in_payload;
  } core_status_t;

endpackage

// File: rtl/tlmd_if.sv
// Handshake channels of the deframer: received bytes, results, configuration writes.
interface tlmd_byte_if import tlmd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlmd_result_if import tlmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_error;
  logic [2:0]       error_code;
  logic [7:0]       msg_type;
  logic [LEN_W-1:0] msg_length;
  logic [7:0]       payload_byte;
  logic             last_byte;

  modport source (output valid, output is_error, output error_code, output msg_type,
                  output msg_length, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input is_error, input error_code, input msg_type,
                  input msg_length, input payload_byte, input last_byte, output ready);
endinterface

interface tlmd_cfg_if import tlmd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tlmd_regs.sv
// Type entry register file written through the configuration channel.
module tlmd_regs import tlmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tlmd_cfg_if.sink    cfg,
  output type_entry_t entries [REG_COUNT]
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        entries[i] <= '0;
      end
    end else if (cfg.valid && cfg.index < CFG_INDEX_W'(REG_COUNT)) begin
      // out-of-range indexes fall through and are dropped
      entries[cfg.index[REG_IDX_W-1:0]] <= type_entry_t'(cfg.data);
    end
  end

endmodule

// File: rtl/tlmd_core.sv
// Header collection, type lookup and payload forwarding with input and result registers.
module tlmd_core import tlmd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tlmd_byte_if.sink    rx,
  tlmd_result_if.source res,
  input  type_entry_t  entries [REG_COUNT],
  output core_status_t status
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // deframer state
  phase_t           phase, phase_next;
  logic [2:0]       header_count, header_count_next;
  logic [LEN_W-1:0] length_shift, length_shift_next;
  logic [7:0]       current_type, current_type_next;
  logic [LEN_W-1:0] bytes_received, bytes_received_next;

  // result register
  logic             out_valid;
  logic             out_is_error;
  err_code_t        out_code;
  logic [7:0]       out_type;
  logic [LEN_W-1:0] out_length;
  logic [7:0]       out_payload;
  logic             out_last;

  logic fire;
  assign fire     = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || fire;

  // type lookup: lowest valid matching entry wins
  logic             hit;
  type_entry_t      hit_entry;
  logic [LEN_W-1:0] min_len, max_len;
  err_code_t        check_code;

  always_comb begin
    hit       = 1'b0;
    hit_entry = '0;
    for (int i = LOOKUP_N - 1; i >= 0; i--) begin
      if (entries[i].valid && entries[i].type_id == in_byte) begin
        hit       = 1'b1;
        hit_entry = entries[i];
      end
    end
  end

  assign min_len = {{(LEN_W-LIMIT_WIDTH){1'b0}}, hit_entry.min_len[LIMIT_WIDTH-1:0]};
  assign max_len = {{(LEN_W-LIMIT_WIDTH){1'b0}}, hit_entry.max_len[LIMIT_WIDTH-1:0]};

  always_comb begin
    if (!hit) begin
      check_code = ERR_UNKNOWN_TYPE;
    end else if (length_shift < min_len) begin
      check_code = ERR_TOO_SHORT;
    end else if (!hit_entry.no_limit && length_shift > max_len) begin
      check_code = ERR_TOO_LONG;
    end else if (length_shift == '0) begin
      check_code = ERR_ZERO_LEN;
    end else begin
      check_code = ERR_NONE;
    end
  end

  // per-byte step
  logic             r_valid;
  logic             r_is_error;
  err_code_t        r_code;
  logic [7:0]       r_type;
  logic [7:0]       r_payload;
  logic             r_last;
  logic [LEN_W-1:0] count_inc;

  assign count_inc = bytes_received + 1'b1;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_shift_next   = length_shift;
    current_type_next   = current_type;
    bytes_received_next = bytes_received;
    r_valid    = 1'b0;
    r_is_error = 1'b0;
    r_code     = ERR_NONE;
    r_type     = current_type;
    r_payload  = in_byte;
    r_last     = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (header_count < 3'(HEADER_BYTES - 1)) begin
          length_shift_next = {length_shift[LEN_W-9:0], in_byte};
          header_count_next = header_count + 3'd1;
        end else begin
          current_type_next = in_byte;
          header_count_next = '0;
          if (check_code != ERR_NONE) begin
            phase_next = PH_HALT;
            r_valid    = 1'b1;
            r_is_error = 1'b1;
            r_code     = check_code;
            r_type     = in_byte;
            r_payload  = '0;
          end else begin
            bytes_received_next = '0;
            phase_next          = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_received_next = count_inc;
        r_valid = 1'b1;
        r_last  = (count_inc == length_shift);
        if (r_last) begin
          phase_next        = PH_HEADER;
          header_count_next = '0;
        end
      end
      default: begin
        // halted: bytes are swallowed
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      phase          <= PH_HEADER;
      header_count   <= '0;
      length_shift   <= '0;
      current_type   <= '0;
      bytes_received <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        length_shift   <= length_shift_next;
        current_type   <= current_type_next;
        bytes_received <= bytes_received_next;
        if (r_valid) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
    if (fire && r_valid) begin
      out_is_error <= r_is_error;
      out_code     <= r_code;
      out_type     <= r_type;
      out_length   <= length_shift;
      out_payload  <= r_payload;
      out_last     <= r_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.is_error     = out_is_error;
  assign res.error_code   = out_code;
  assign res.msg_type     = out_type;
  assign res.msg_length   = out_length;
  assign res.payload_byte = out_payload;
  assign res.last_byte    = out_last;

  assign status.in_payload = (phase == PH_DATA);
  assign status.halted     = (phase != PH_HEADER) && (phase != PH_DATA);

endmodule

// File: rtl/type_length_message_deframer.sv
// Type-length message deframer, top level.
//
// rx carries received link bytes one per request. Each message starts with a
// five-byte header: 32-bit big-endian payload length, then a type byte. The
// type is looked up in four type entries written over cfg (index 0..3, other
// indexes dropped); the lowest valid match sets the length limits.
// res carries one result per payload byte (type, length, byte, last mark) or
// one error result for a bad header, after which every byte is swallowed
// until reset. Header bytes give no result.
// A byte lands in the input register, and its result is then captured in the
// result register; a stall on res can hold it in the input register first.
// Throughput: one byte per cycle while res takes results; the type lookup and
// length compares sit between the input and result registers and never iterate.
// When res stalls, the held result stays put and the input register takes one
// more byte; rx.ready drops after that until res drains.
// rst (synchronous) clears the type entries, the header state and both
// registers. cfg.ready is always high; write entries only while idle.
`include "type_length_message_deframer_assert.svh"

module type_length_message_deframer import tlmd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tlmd_byte_if.sink     rx,
  tlmd_result_if.source res,
  tlmd_cfg_if.sink      cfg
);

  type_entry_t  entries [REG_COUNT];
  core_status_t status;

  tlmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .entries (entries)
  );

  tlmd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .res     (res),
    .entries (entries),
    .status  (status)
  );

  // once halted, stays halted until reset
  `TLMD_ASSERT_NEXT(a_halt_sticky, clk, rst, status.halted, status.halted)
  // nothing new comes out once halted and drained
  `TLMD_ASSERT_NEXT(a_halt_silent, clk, rst, status.halted && !res.valid, !res.valid)
  // an error result is only ever shown while halted
  `TLMD_ASSERT_NOW(a_err_halts, clk, rst, res.valid && res.is_error, status.halted)
  // in header phase with an empty output, only an error can appear next
  `TLMD_ASSERT_NEXT(a_hdr_no_payload, clk, rst,
    !status.in_payload && !status.halted && !res.valid, !res.valid || res.is_error)

endmodule

// File: verif/deframe_checker.sv
// Deframer checker: tracks the type table and header state, predicts every result and compares.
module deframe_checker import tlmd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tlmd_byte_if   rx,
  tlmd_result_if res,
  tlmd_cfg_if    cfg,
  output int     fails,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             is_error;
    err_code_t        code;
    logic [7:0]       msg_type;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       payload;
    logic             last;
  } frame_out_t;

  type_entry_t      entry_regs [REG_COUNT];
  phase_t           ph;
  logic [2:0]       hdr_seen;
  logic [LEN_W-1:0] len_acc;
  logic [7:0]       cur_type;
  logic [LEN_W-1:0] paid;
  frame_out_t       predicted_out [$];
  int               mismatches = 0;

  // lowest valid entry with a matching type decides the limits
  function automatic err_code_t header_verdict(input logic [7:0] t, input logic [LEN_W-1:0] len);
    int          hit;
    type_entry_t e;
    hit = -1;
    for (int i = 0; i < LOOKUP_N; i++)
      if (hit < 0 && entry_regs[i].valid && entry_regs[i].type_id == t) hit = i;
    if (hit < 0) return ERR_UNKNOWN_TYPE;
    e = entry_regs[hit];
    if (len < LEN_W'(e.min_len[LIMIT_WIDTH-1:0])) return ERR_TOO_SHORT;
    if (!e.no_limit && len > LEN_W'(e.max_len[LIMIT_WIDTH-1:0])) return ERR_TOO_LONG;
    if (len == '0) return ERR_ZERO_LEN;
    return ERR_NONE;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_out_t r;
    err_code_t  code;
    case (ph)
      PH_HEADER: begin
        if (hdr_seen < 3'(HEADER_BYTES - 1)) begin
          len_acc  = {len_acc[LEN_W-9:0], b};
          hdr_seen = hdr_seen + 3'd1;
        end else begin
          cur_type = b;
          hdr_seen = '0;
          code = header_verdict(b, len_acc);
          if (code != ERR_NONE) begin
            ph = PH_HALT;
            r = '{1'b1, code, b, len_acc, 8'h00, 1'b0};
            predicted_out.push_back(r);
          end else begin
            paid = '0;
            ph   = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        paid = paid + 1'b1;
        r = '{1'b0, ERR_NONE, cur_type, len_acc, b, paid == len_acc};
        predicted_out.push_back(r);
        if (paid == len_acc) begin
          ph       = PH_HEADER;
          hdr_seen = '0;
        end
      end
      default: ; // halted: bytes are swallowed until reset
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_result();
    frame_out_t want;
    if (predicted_out.size() == 0) begin
      mismatches++;
      $display("%0t result with none expected: error %0b code %0d type %0h length %0h byte %0h",
               $time, res.is_error, res.error_code, res.msg_type, res.msg_length,
               res.payload_byte);
      return;
    end
    want = predicted_out.pop_front();
    check_field("is_error", want.is_error, res.is_error);
    check_field("error_code", want.code, res.error_code);
    check_field("msg_type", want.msg_type, res.msg_type);
    check_field("msg_length", want.msg_length, res.msg_length);
    check_field("payload_byte", want.payload, res.payload_byte);
    check_field("last_byte", want.last, res.last_byte);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph       = PH_HEADER;
      hdr_seen = '0;
      len_acc  = '0;
      cur_type = '0;
      paid     = '0;
      foreach (entry_regs[i]) entry_regs[i] = '0;
      predicted_out.delete();
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < REG_COUNT)
        entry_regs[cfg.index[REG_IDX_W-1:0]] = cfg.data;
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
      if (res.valid && res.ready) compare_result();
    end
    pending <= predicted_out.size();
    fails   <= mismatches;
  end

endmodule

// File: verif/tb.sv
// Deframer testbench top: clock, reset, byte and table stimulus, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlmd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int BYTE_TARGET   = 880;

  logic        clk;
  logic        rst;
  int          fails;
  int          pending;
  bit          calm;
  int          sent;
  int          stalled;
  type_entry_t plan [REG_COUNT];

  tlmd_byte_if   rx_ch ();
  tlmd_result_if res_ch ();
  tlmd_cfg_if    cfg_ch ();

  type_length_message_deframer u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  deframe_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 12) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sent++;
    calm <= (sent >= 350 && sent < 520);
  endtask

  // sender holds off until every predicted result has come back
  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_plan(input bit with_stray);
    int stray_at;
    stray_at = with_stray ? $urandom_range(REG_COUNT) : -1;
    for (int i = 0; i <= REG_COUNT; i++) begin
      if (i == stray_at)
        cfg_write(CFG_INDEX_W'($urandom_range(REG_COUNT, 255)), CFG_DATA_W'({$urandom, $urandom}));
      if (i < REG_COUNT) cfg_write(CFG_INDEX_W'(i), plan[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_header(input logic [7:0] t, input logic [LEN_W-1:0] len);
    for (int k = 3; k >= 0; k--) push_byte(len[8*k +: 8]);
    push_byte(t);
  endtask

  task automatic send_message(input logic [7:0] t, input int unsigned len);
    send_header(t, len);
    for (int unsigned n = 0; n < len; n++) begin
      if (n == len / 2 && n != 0 && $urandom_range(15) == 0) drain();
      push_byte(8'($urandom));
    end
  endtask

  function automatic bit entry_usable(input int i);
    int unsigned lo;
    if (!plan[i].valid) return 1'b0;
    for (int j = 0; j < i; j++)
      if (plan[j].valid && plan[j].type_id == plan[i].type_id) return 1'b0;
    lo = (plan[i].min_len == 0) ? 1 : plan[i].min_len;
    return lo <= 40 && (plan[i].no_limit || plan[i].max_len >= lo);
  endfunction

  task automatic randomize_plan();
    for (int i = 0; i < REG_COUNT; i++) begin
      plan[i].valid    = ($urandom_range(7) != 0);
      plan[i].type_id  = (i > 0 && $urandom_range(3) == 0) ?
                         plan[$urandom_range(i - 1)].type_id : 8'($urandom);
      plan[i].min_len  = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(6));
      case ($urandom_range(5))
        0:       plan[i].max_len = 24'hFFFFFF;
        1:       plan[i].max_len = 24'($urandom);
        default: plan[i].max_len = plan[i].min_len + 24'($urandom_range(30));
      endcase
      plan[i].no_limit = ($urandom_range(3) == 0);
    end
  endtask

  task automatic random_messages(input int count);
    int          usable [$];
    int          pick;
    int unsigned lo;
    int unsigned hi;
    for (int i = 0; i < REG_COUNT; i++)
      if (entry_usable(i)) usable.push_back(i);
    for (int m = 0; m < count; m++) begin
      if (sent >= BYTE_TARGET) break;
      pick = usable[$urandom_range(usable.size() - 1)];
      lo = (plan[pick].min_len == 0) ? 1 : plan[pick].min_len;
      hi = lo + (($urandom_range(19) == 0) ? 160 : 10);
      if (!plan[pick].no_limit && plan[pick].max_len < hi) hi = plan[pick].max_len;
      send_message(plan[pick].type_id, $urandom_range(lo, hi));
    end
  endtask

  task automatic fatal_header();
    logic [7:0]  t;
    int unsigned short_min;
    int unsigned long_max;
    t         = 8'($urandom);
    short_min = $urandom_range(1, 24'hFFFFFF);
    long_max  = $urandom_range(0, 24'hFFFFFE);
    plan[0] = '{valid: 1'b1, no_limit: 1'b0, max_len: 24'hFFFFFF,
                min_len: 24'(short_min), type_id: t};
    plan[1] = '{valid: 1'b1, no_limit: 1'b0, max_len: 24'(long_max),
                min_len: 24'd0, type_id: t + 8'd1};
    plan[2] = '{valid: 1'b1, no_limit: 1'b1, max_len: 24'($urandom),
                min_len: 24'd0, type_id: t + 8'd2};
    plan[3] = '{valid: 1'b0, no_limit: 1'($urandom), max_len: 24'($urandom),
                min_len: 24'($urandom), type_id: t + 8'd3};
    program_plan(1'b0);
    case ($urandom_range(ERR_UNKNOWN_TYPE, ERR_ZERO_LEN))
      ERR_UNKNOWN_TYPE: send_header(t + 8'd3, $urandom);
      ERR_TOO_SHORT:    send_header(t, $urandom_range(0, short_min - 1));
      ERR_TOO_LONG:     send_header(t + 8'd1, $urandom_range(long_max + 1, 32'hFFFFFFFF));
      default:          send_header(t + 8'd2, 0);
    endcase
  endtask

  initial begin
    rst           <= 1'b1;
    calm          <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // priority of the lowest match, an invalid entry skipped, no-limit over max 0,
    // and an all-ones entry shadowed by entry zero
    plan[0] = '{valid: 1'b1, no_limit: 1'b0, max_len: 24'd4, min_len: 24'd1, type_id: 8'hFF};
    plan[1] = '{valid: 1'b0, no_limit: 1'b0, max_len: 24'd0, min_len: 24'd0, type_id: 8'h00};
    plan[2] = '{valid: 1'b1, no_limit: 1'b1, max_len: 24'd0, min_len: 24'd0, type_id: 8'h00};
    plan[3] = '1;
    program_plan(1'b1);
    send_message(8'hFF, 1);
    send_message(8'hFF, 4);
    send_message(8'h00, 3);

    while (sent < BYTE_TARGET) begin
      settle();
      randomize_plan();
      if (!entry_usable(0) && !entry_usable(1) && !entry_usable(2) && !entry_usable(3))
        plan[0] = '{valid: 1'b1, no_limit: 1'b0, max_len: 24'hFFFFFF, min_len: 24'd0,
                    type_id: 8'($urandom)};
      program_plan($urandom_range(2) == 0);
      random_messages($urandom_range(4, 12));
    end

    // one bad header ends the run: the block halts and swallows the rest
    settle();
    fatal_header();
    repeat (20) push_byte(8'($urandom));
    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
